/* design/priority_batch_scheduler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the priority batch scheduler
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BATCH_SCHEDULER_ASSERT_SVH
`define PRIORITY_BATCH_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBS_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Field widths and the stored job record of the priority batch scheduler.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int ID_W    = 6;
    localparam int TIME_W  = 16;
    localparam int PRI_W   = 8;
    localparam int START_W = 23;
    localparam int WAIT_W  = 23;
    localparam int TURN_W  = 24;
    localparam int TOTW_W  = 29;
    localparam int TOTT_W  = 30;
    localparam int JCNT_W  = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 160;

    // One job as it sits in the job memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  priority_val;
    } job_t;

endpackage

/* design/priority_batch_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_batch_scheduler
// Non-preemptive priority scheduling of one batch of jobs, kept sorted in a
// synchronous job memory and replayed in schedule order with timing figures.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready| one job, tlast closes batch
//  m_axis   | out       | m_axis_tvalid / m_axis_tready| one scheduled job result
//
// Loading a job into an empty or full memory needs no walk; otherwise the insertion
// walks the sorted memory one entry per cycle, shifting up each stored job with a
// larger priority value, then writes the job into the freed slot. The item marked last
// starts the replay: each result takes a memory read, then an output compute, plus any output stalls.
// Input is accepted only while idle, including while the final result still waits.
// Reset clears control state and totals; the job memory keeps its old contents.
//
module priority_batch_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // s_axis_tdata, from bit 0: job_id[5:0], arrival[21:6], burst[37:22],
    // priority_req[45:38], zero fill[47:46]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    // m_axis_tdata, from bit 0: out_job_id[5:0], out_arrival[21:6],
    // out_burst[37:22], out_priority[45:38], waiting[68:46],
    // turnaround[92:69], total_waiting[121:93], total_turnaround[151:122],
    // job_count[158:152], zero fill[159]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    import pbs_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_INS       = 3'd1;
    localparam logic [2:0] ST_PUT       = 3'd2;
    localparam logic [2:0] ST_EMIT_RD   = 3'd3;
    localparam logic [2:0] ST_EMIT_CALC = 3'd4;

    // The job memory, sorted by ascending priority value, ties in load order.
    job_t            job_mem [MAX_JOBS];
    job_t            rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    job_t            mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     emit_idx_reg, emit_idx_next;
    job_t              new_job_reg, new_job_next;
    logic              new_last_reg, new_last_next;
    logic [START_W-1:0] run_finish_reg, run_finish_next;
    logic [TOTW_W-1:0] tot_wait_reg, tot_wait_next;
    logic [TOTT_W-1:0] tot_turn_reg, tot_turn_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              s_accept;
    job_t              in_job;
    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     ptr_m1;
    logic [CW-1:0]     ptr_m2;
    logic              ins_done;
    logic              emit_load;
    logic              emit_last;

    // Timing figures of the job being replayed.
    logic [START_W-1:0] start_time;
    logic [TURN_W-1:0]  finish_time;
    logic [TURN_W-1:0]  wait_full;
    logic [TURN_W:0]    turn_full;
    logic [TOTW_W-1:0]  tot_wait_sum;
    logic [TOTT_W-1:0]  tot_turn_sum;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_job.id           = s_axis_tdata[5:0];
    assign in_job.arrival      = s_axis_tdata[21:6];
    assign in_job.burst        = s_axis_tdata[37:22];
    assign in_job.priority_val = s_axis_tdata[45:38];

    assign count_m1 = count_reg - 1'b1;
    assign ptr_m1   = ptr_reg - 1'b1;
    assign ptr_m2   = ptr_reg - 2'd2;

    // The first job of the schedule starts at its own arrival.
    assign start_time  = (emit_idx_reg == '0) ? {7'd0, rd_data_reg.arrival} : run_finish_reg;
    assign finish_time = {1'b0, start_time} + {8'd0, rd_data_reg.burst};
    assign wait_full   = {1'b0, start_time} - {8'd0, rd_data_reg.arrival};
    assign turn_full   = {1'b0, finish_time} - {9'd0, rd_data_reg.arrival};
    assign tot_wait_sum = tot_wait_reg + {{(TOTW_W - TURN_W){wait_full[TURN_W-1]}}, wait_full};
    assign tot_turn_sum = tot_turn_reg + {{(TOTT_W - TURN_W - 1){turn_full[TURN_W]}}, turn_full};

    assign emit_load = (state_reg == ST_EMIT_CALC) && (!out_valid_reg || m_axis_tready);
    assign emit_last = (emit_idx_reg == count_m1[AW-1:0]);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        emit_idx_next   = emit_idx_reg;
        new_job_next    = new_job_reg;
        new_last_next   = new_last_reg;
        run_finish_next = run_finish_reg;
        tot_wait_next   = tot_wait_reg;
        tot_turn_next   = tot_turn_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = new_job_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        ins_done        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    new_job_next  = in_job;
                    new_last_next = s_axis_tlast;
                    emit_idx_next = '0;
                    if (count_reg == CW'(MAX_JOBS))
                    begin
                        // Memory full: the job is dropped, a last mark still closes.
                        state_next = s_axis_tlast ? ST_EMIT_RD : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = in_job;
                        count_next = CW'(1);
                        state_next = s_axis_tlast ? ST_EMIT_RD : ST_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = count_m1[AW-1:0];
                        ptr_next   = count_reg;
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                // rd_data_reg holds the entry at ptr - 1, just below the free slot at ptr.
                if (rd_data_reg.priority_val > new_job_reg.priority_val)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = rd_data_reg;
                    ptr_next  = ptr_m1;
                    if (ptr_m1 == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_m2[AW-1:0];
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = new_job_reg;
                    ins_done  = 1'b1;
                end
            end
            ST_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_job_reg;
                ins_done  = 1'b1;
            end
            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = emit_idx_reg;
                state_next = ST_EMIT_CALC;
            end
            ST_EMIT_CALC:
            begin
                if (emit_load)
                begin
                    out_data_next = {1'b0,
                                     emit_last ? JCNT_W'(count_reg) : {JCNT_W{1'b0}},
                                     emit_last ? tot_turn_sum : {TOTT_W{1'b0}},
                                     emit_last ? tot_wait_sum : {TOTW_W{1'b0}},
                                     turn_full[TURN_W-1:0],
                                     wait_full[WAIT_W-1:0],
                                     rd_data_reg.priority_val,
                                     rd_data_reg.burst,
                                     rd_data_reg.arrival,
                                     rd_data_reg.id};
                    out_last_next = emit_last;
                    if (emit_last)
                    begin
                        // Batch closed: ready for the next one.
                        count_next      = '0;
                        run_finish_next = '0;
                        tot_wait_next   = '0;
                        tot_turn_next   = '0;
                        emit_idx_next   = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        run_finish_next = finish_time[START_W-1:0];
                        tot_wait_next   = tot_wait_sum;
                        tot_turn_next   = tot_turn_sum;
                        emit_idx_next   = emit_idx_reg + 1'b1;
                        state_next      = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_done)
        begin
            count_next = count_reg + 1'b1;
            state_next = new_last_reg ? ST_EMIT_RD : ST_IDLE;
        end
    end

    // The output register is refilled only when it is empty or being taken.
    always_comb
    begin
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            emit_idx_reg   <= '0;
            new_last_reg   <= 1'b0;
            run_finish_reg <= '0;
            tot_wait_reg   <= '0;
            tot_turn_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            emit_idx_reg   <= emit_idx_next;
            new_last_reg   <= new_last_next;
            run_finish_reg <= run_finish_next;
            tot_wait_reg   <= tot_wait_next;
            tot_turn_reg   <= tot_turn_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_job_reg  <= new_job_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Job memory: one write port, one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= job_mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`include "priority_batch_scheduler_assert.svh"

    `PBS_ASSERT_SAME(a_no_overwrite, emit_load, (!out_valid_reg || m_axis_tready), "result overwritten while stalled")
    `PBS_ASSERT_NEXT(a_batch_closes, (emit_load && emit_last), (count_reg == '0 && state_reg == ST_IDLE), "batch did not close after last result")
    `PBS_ASSERT_SAME(a_ins_ptr, (state_reg == ST_INS), (ptr_reg != '0 && ptr_reg < count_reg + 1'b1), "insert pointer out of range")
    `PBS_ASSERT_SAME(a_emit_idx, (state_reg == ST_EMIT_CALC), (CW'(emit_idx_reg) < count_reg), "replay index beyond stored jobs")

endmodule
